// File: hw/rtl/ptlc_pkg.sv
// Package for the proximity trigger link controller.
// Holds the event, mode and command codes and the item, result and register types.
// No dependencies.
package ptlc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 26;
  localparam int unsigned S_DATA_W  = 40;
  localparam int unsigned S_USER_W  = 3;
  localparam int unsigned M_DATA_W  = 32;

  localparam logic [15:0] VALID_LIMIT = 16'd2000;

  typedef enum logic [1:0] {
    MODE_ADV   = 2'd0,
    MODE_CONN  = 2'd1,
    MODE_POLL  = 2'd2,
    MODE_SLEEP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_LINK_UP   = 3'd1,
    REQ_LINK_DOWN = 3'd2,
    REQ_CMD       = 3'd3,
    REQ_SAMPLE    = 3'd4,
    REQ_BUTTON    = 3'd5
  } req_t;

  localparam logic [7:0] CMD_POLL_ON   = 8'h01;
  localparam logic [7:0] CMD_POLL_OFF  = 8'h02;
  localparam logic [7:0] CMD_SLEEP     = 8'h03;
  localparam logic [7:0] CMD_PING      = 8'h05;
  localparam logic [7:0] CMD_SND_OK    = 8'h10;
  localparam logic [7:0] CMD_SND_BAD   = 8'h11;
  localparam logic [7:0] ARG_CORRECT   = 8'h01;

  localparam logic [2:0] SND_NONE      = 3'd0;
  localparam logic [2:0] SND_CORRECT   = 3'd1;
  localparam logic [2:0] SND_INCORRECT = 3'd2;
  localparam logic [2:0] SND_LINK_UP   = 3'd3;
  localparam logic [2:0] SND_LINK_DOWN = 3'd4;

  localparam logic [1:0] MSG_NONE   = 2'd0;
  localparam logic [1:0] MSG_DETECT = 2'd1;
  localparam logic [1:0] MSG_BATT   = 2'd2;
  localparam logic [1:0] MSG_SLEEP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ADV_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INACT_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd5;

  typedef struct packed {
    logic [25:0] advertise_timeout_ms;
    logic [25:0] inactivity_timeout_ms;
    logic [10:0] window_min_mm;
    logic [10:0] window_max_mm;
    logic [15:0] cooldown_ms;
    logic [15:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  cmd_code;
    logic        cmd_has_arg;
    logic [7:0]  cmd_arg;
    logic [15:0] distance_mm;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  sound;
    logic [1:0]  message;
    logic [15:0] report_distance;
    logic        start_advertising;
    logic        sleep_now;
  } res_t;

endpackage

// File: hw/rtl/ptlc_cfg.sv
// Configuration register file of the proximity trigger link controller.
// Depends on ptlc_pkg for register indexes and the cfg_t bundle.
module ptlc_cfg
  import ptlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.advertise_timeout_ms  <= 26'd300000;
      cfg.inactivity_timeout_ms <= 26'd1800000;
      cfg.window_min_mm         <= 11'd50;
      cfg.window_max_mm         <= 11'd1000;
      cfg.cooldown_ms           <= 16'd500;
      cfg.debounce_ms           <= 16'd150;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ADV_TIMEOUT:   cfg.advertise_timeout_ms  <= cfg_data;
        REG_INACT_TIMEOUT: cfg.inactivity_timeout_ms <= cfg_data;
        REG_WIN_MIN:       cfg.window_min_mm         <= cfg_data[10:0];
        REG_WIN_MAX:       cfg.window_max_mm         <= cfg_data[10:0];
        REG_COOLDOWN:      cfg.cooldown_ms           <= cfg_data[15:0];
        REG_DEBOUNCE:      cfg.debounce_ms           <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/ptlc_engine.sv
// Mode state, timestamps and per-event step logic of the controller.
// Depends on ptlc_pkg; state advances on each processed item.
module ptlc_engine
  import ptlc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  mode_t             mode;
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] mode_start_ms;
  logic [TIME_W-1:0] activity_ms;
  logic [TIME_W-1:0] detect_ms;
  logic [TIME_W-1:0] button_ms;
  logic              target_present;
  logic              link_up_flag;
  logic              is_correct_target;

  mode_t             mode_next;
  logic [TIME_W-1:0] now_ms_next;
  logic [TIME_W-1:0] mode_start_ms_next;
  logic [TIME_W-1:0] activity_ms_next;
  logic [TIME_W-1:0] detect_ms_next;
  logic [TIME_W-1:0] button_ms_next;
  logic              target_present_next;
  logic              link_up_flag_next;
  logic              is_correct_target_next;

  mode_t             new_mode;
  logic              sleep_go;
  logic              asleep;
  logic              in_window;
  logic              sample_ok;
  logic [TIME_W-1:0] tick_now;
  logic [TIME_W-1:0] idle_age;
  logic [TIME_W-1:0] adv_age;
  logic [TIME_W-1:0] detect_age;
  logic [TIME_W-1:0] button_age;
  logic [15:0]       sample_mm;

  assign asleep     = (mode == MODE_SLEEP);
  assign sample_mm  = item.distance_mm;
  assign tick_now   = now_ms + 32'd1;
  assign idle_age   = tick_now - activity_ms;
  assign adv_age    = tick_now - mode_start_ms;
  assign detect_age = now_ms - detect_ms;
  assign button_age = now_ms - button_ms;
  assign sample_ok  = (sample_mm != 16'd0) && (sample_mm < VALID_LIMIT);
  assign in_window  = sample_ok && (sample_mm > {5'd0, cfg.window_min_mm})
                      && (sample_mm < {5'd0, cfg.window_max_mm});

  always_comb begin
    now_ms_next            = now_ms;
    mode_next              = mode;
    mode_start_ms_next     = mode_start_ms;
    activity_ms_next       = activity_ms;
    detect_ms_next         = detect_ms;
    button_ms_next         = button_ms;
    target_present_next    = target_present;
    link_up_flag_next      = link_up_flag;
    is_correct_target_next = is_correct_target;
    new_mode               = mode;
    sleep_go               = 1'b0;
    res                    = '0;

    case (item.req_type)
      REQ_TICK: begin
        now_ms_next = tick_now;
        if (!asleep) begin
          if (idle_age > {6'd0, cfg.inactivity_timeout_ms}) begin
            sleep_go = 1'b1;
          end else if (mode == MODE_ADV && adv_age > {6'd0, cfg.advertise_timeout_ms}) begin
            sleep_go = 1'b1;
          end
        end
      end
      REQ_LINK_UP: begin
        if (!asleep) begin
          link_up_flag_next = 1'b1;
          activity_ms_next  = now_ms;
          res.sound         = SND_LINK_UP;
          if (mode == MODE_ADV) begin
            new_mode = MODE_CONN;
          end
        end
      end
      REQ_LINK_DOWN: begin
        if (!asleep) begin
          link_up_flag_next = 1'b0;
          res.sound         = SND_LINK_DOWN;
          new_mode          = MODE_ADV;
        end
      end
      REQ_CMD: begin
        if (mode == MODE_CONN || mode == MODE_POLL) begin
          activity_ms_next       = now_ms;
          is_correct_target_next = item.cmd_has_arg && (item.cmd_arg == ARG_CORRECT);
          case (item.cmd_code)
            CMD_POLL_ON: begin
              if (mode == MODE_CONN) begin
                new_mode = MODE_POLL;
              end
            end
            CMD_POLL_OFF: begin
              if (mode == MODE_POLL) begin
                new_mode = MODE_CONN;
              end
            end
            CMD_SLEEP:     sleep_go    = 1'b1;
            CMD_PING:      res.message = MSG_BATT;
            CMD_SND_OK:    res.sound   = SND_CORRECT;
            CMD_SND_BAD:   res.sound   = SND_INCORRECT;
            default: ;
          endcase
        end
      end
      REQ_SAMPLE: begin
        if (mode == MODE_POLL) begin
          if (in_window) begin
            if (!target_present && detect_age >= {16'd0, cfg.cooldown_ms}) begin
              res.sound           = is_correct_target ? SND_CORRECT : SND_INCORRECT;
              res.message         = MSG_DETECT;
              res.report_distance = sample_mm;
              activity_ms_next    = now_ms;
              detect_ms_next      = now_ms;
              target_present_next = 1'b1;
              new_mode            = MODE_CONN;
            end
          end else if (sample_mm > {5'd0, cfg.window_max_mm} || sample_mm > VALID_LIMIT) begin
            target_present_next = 1'b0;
          end
        end
      end
      REQ_BUTTON: begin
        if (asleep) begin
          new_mode               = MODE_ADV;
          activity_ms_next       = now_ms;
          detect_ms_next         = now_ms;
          button_ms_next         = now_ms;
          target_present_next    = 1'b0;
          link_up_flag_next      = 1'b0;
          is_correct_target_next = 1'b0;
        end else if (button_age >= {16'd0, cfg.debounce_ms}) begin
          button_ms_next   = now_ms;
          activity_ms_next = now_ms;
        end
      end
      default: ;
    endcase

    if (sleep_go) begin
      if (link_up_flag) begin
        res.message = MSG_SLEEP;
      end
      link_up_flag_next = 1'b0;
      res.sleep_now     = 1'b1;
      new_mode          = MODE_SLEEP;
    end

    if (new_mode != mode) begin
      mode_next          = new_mode;
      mode_start_ms_next = now_ms_next;
      if (new_mode == MODE_ADV) begin
        res.start_advertising = 1'b1;
      end
    end

    res.mode = mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_ADV;
      now_ms            <= '0;
      mode_start_ms     <= '0;
      activity_ms       <= '0;
      detect_ms         <= '0;
      button_ms         <= '0;
      target_present    <= 1'b0;
      link_up_flag      <= 1'b0;
      is_correct_target <= 1'b0;
    end else if (advance) begin
      mode              <= mode_next;
      now_ms            <= now_ms_next;
      mode_start_ms     <= mode_start_ms_next;
      activity_ms       <= activity_ms_next;
      detect_ms         <= detect_ms_next;
      button_ms         <= button_ms_next;
      target_present    <= target_present_next;
      link_up_flag      <= link_up_flag_next;
      is_correct_target <= is_correct_target_next;
    end
  end

endmodule

// File: hw/rtl/proximity_trigger_link_controller_core.sv
// Proximity trigger link controller: input register, step engine, result register.
// Depends on ptlc_pkg, ptlc_cfg and ptlc_engine.
//
// Usage:
//   Events enter on the s_ channel (kind in s_tuser, command and range fields in
//   s_tdata); one result per event leaves on the m_ channel. A transfer happens
//   at a rising edge with tvalid and tready both high.
//   Each event sits in the input register, then the step logic loads the result
//   register and m_tvalid rises. Throughput: one event per cycle while the
//   result register is not stalled; the mode and timestamp registers are read
//   and written by the step logic as the event advances.
//   When the receiver stalls, the result register holds, the event behind it
//   holds in the input register, and s_tready drops until m_tready returns.
//   Registers are to be written through cfg_we/cfg_index/cfg_data while no event
//   is in flight; the block does not enforce it. Unlisted indexes are ignored.
//   Reset (rst, synchronous) empties both registers, loads the register
//   defaults, puts the unit in advertising and clears the millisecond clock.
module proximity_trigger_link_controller_core
  import ptlc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cmd_code[7:0], cmd_has_arg[8], cmd_arg[16:9], distance_mm[32:17], zero [39:33]
  input  logic [S_DATA_W-1:0]  s_tdata,
  // req_type[2:0]
  input  logic [S_USER_W-1:0]  s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // mode[1:0], sound[4:2], message[6:5], report_distance[22:7],
  // start_advertising[23], sleep_now[24], zero [31:25]
  output logic [M_DATA_W-1:0]  m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  res_t  step_res;
  res_t  out_res;
  logic  out_valid;
  logic  advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type    <= s_tuser;
      in_item.cmd_code    <= s_tdata[7:0];
      in_item.cmd_has_arg <= s_tdata[8];
      in_item.cmd_arg     <= s_tdata[16:9];
      in_item.distance_mm <= s_tdata[32:17];
    end
  end

  ptlc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptlc_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.sleep_now, out_res.start_advertising,
                     out_res.report_distance, out_res.message, out_res.sound,
                     out_res.mode};

`ifndef SYNTHESIS
  a_sleep_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.sleep_now) |-> (out_res.mode == MODE_SLEEP))
    else $error("sleep_now without sleeping mode");

  a_adv_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.start_advertising) |-> (out_res.mode == MODE_ADV))
    else $error("start_advertising without advertising mode");

  a_detect_report: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.message == MSG_DETECT)
      |-> (out_res.mode == MODE_CONN && out_res.report_distance != 16'd0))
    else $error("detection report malformed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without output backpressure");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for proximity_trigger_link_controller_core: directed table, then random
// event streams under several register settings, each result checked against a local model.
// Depends on ptlc_pkg and the core RTL.
module testbench;
  import ptlc_pkg::*;

  localparam logic [2:0]  REQ_UNUSED     = 3'd6;
  localparam logic [15:0] NO_ECHO_MM     = 16'd9999;
  localparam int          IDLE_PCT       = 13;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 6;

  typedef enum logic [1:0] {ROW_STEP, ROW_CHECKED, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    item_t                item;
    res_t                 want;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic [S_USER_W-1:0]  s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // model registers
  logic [25:0] adv_limit  = 26'd300000;
  logic [25:0] idle_limit = 26'd1800000;
  logic [10:0] win_lo     = 11'd50;
  logic [10:0] win_hi     = 11'd1000;
  logic [15:0] cool_ms    = 16'd500;
  logic [15:0] press_gap  = 16'd150;

  // model state
  mode_t       cur_mode     = MODE_ADV;
  logic [31:0] now_ms       = '0;
  logic [31:0] mode_t0      = '0;
  logic [31:0] active_ms    = '0;
  logic [31:0] last_detect  = '0;
  logic [31:0] last_press   = '0;
  logic        present      = 1'b0;
  logic        linked       = 1'b0;
  logic        right_target = 1'b0;

  res_t      pending_results[$];
  stim_row_t opening_rows[$];
  int        idle_pct = IDLE_PCT;
  int        mismatches = 0;
  int        results_seen = 0;
  int        quiet = 0;

  proximity_trigger_link_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic res_t advance_unit(input item_t it);
    res_t        r;
    mode_t       nxt;
    logic        doze;
    logic [15:0] d;
    r = '0;
    nxt = cur_mode;
    doze = 1'b0;
    d = it.distance_mm;
    case (it.req_type)
      REQ_TICK: begin
        now_ms = now_ms + 32'd1;
        if (cur_mode != MODE_SLEEP)
          doze = (now_ms - active_ms > 32'(idle_limit)) ||
                 (cur_mode == MODE_ADV && now_ms - mode_t0 > 32'(adv_limit));
      end
      REQ_LINK_UP: if (cur_mode != MODE_SLEEP) begin
        linked = 1'b1;
        active_ms = now_ms;
        r.sound = SND_LINK_UP;
        if (cur_mode == MODE_ADV) nxt = MODE_CONN;
      end
      REQ_LINK_DOWN: if (cur_mode != MODE_SLEEP) begin
        linked = 1'b0;
        r.sound = SND_LINK_DOWN;
        nxt = MODE_ADV;
      end
      REQ_CMD: if (cur_mode == MODE_CONN || cur_mode == MODE_POLL) begin
        active_ms = now_ms;
        right_target = it.cmd_has_arg && it.cmd_arg == ARG_CORRECT;
        case (it.cmd_code)
          CMD_POLL_ON:   if (cur_mode == MODE_CONN) nxt = MODE_POLL;
          CMD_POLL_OFF:  if (cur_mode == MODE_POLL) nxt = MODE_CONN;
          CMD_SLEEP:     doze = 1'b1;
          CMD_PING:      r.message = MSG_BATT;
          CMD_SND_OK:    r.sound = SND_CORRECT;
          CMD_SND_BAD:   r.sound = SND_INCORRECT;
          default: ;
        endcase
      end
      REQ_SAMPLE: if (cur_mode == MODE_POLL) begin
        if (d > 16'd0 && d < VALID_LIMIT && d > 16'(win_lo) && d < 16'(win_hi)) begin
          if (!present && now_ms - last_detect >= 32'(cool_ms)) begin
            r.sound = right_target ? SND_CORRECT : SND_INCORRECT;
            r.message = MSG_DETECT;
            r.report_distance = d;
            active_ms = now_ms;
            last_detect = now_ms;
            present = 1'b1;
            nxt = MODE_CONN;
          end
        end else if (d > 16'(win_hi) || d > VALID_LIMIT) begin
          present = 1'b0;
        end
      end
      REQ_BUTTON: if (cur_mode == MODE_SLEEP) begin
        nxt = MODE_ADV;
        active_ms = now_ms;
        last_detect = now_ms;
        last_press = now_ms;
        present = 1'b0;
        linked = 1'b0;
        right_target = 1'b0;
      end else if (now_ms - last_press >= 32'(press_gap)) begin
        last_press = now_ms;
        active_ms = now_ms;
      end
      default: ;
    endcase
    if (doze) begin
      if (linked) r.message = MSG_SLEEP;
      linked = 1'b0;
      r.sleep_now = 1'b1;
      nxt = MODE_SLEEP;
    end
    if (nxt != cur_mode) begin
      if (nxt == MODE_ADV) r.start_advertising = 1'b1;
      cur_mode = nxt;
      mode_t0 = now_ms;
    end
    r.mode = cur_mode;
    return r;
  endfunction

  function automatic item_t random_event();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30)      it.req_type = REQ_TICK;
    else if (pick < 38) it.req_type = REQ_LINK_UP;
    else if (pick < 42) it.req_type = REQ_LINK_DOWN;
    else if (pick < 64) it.req_type = REQ_CMD;
    else if (pick < 92) it.req_type = REQ_SAMPLE;
    else if (pick < 98) it.req_type = REQ_BUTTON;
    else                it.req_type = 3'($urandom_range(7, 6));
    pick = $urandom_range(99);
    if (pick < 25)      it.cmd_code = CMD_POLL_ON;
    else if (pick < 35) it.cmd_code = CMD_POLL_OFF;
    else if (pick < 40) it.cmd_code = CMD_SLEEP;
    else if (pick < 50) it.cmd_code = CMD_PING;
    else if (pick < 60) it.cmd_code = CMD_SND_OK;
    else if (pick < 70) it.cmd_code = CMD_SND_BAD;
    else                it.cmd_code = 8'($urandom);
    it.cmd_has_arg = 1'($urandom);
    it.cmd_arg = ($urandom_range(1) == 0) ? ARG_CORRECT : 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.distance_mm = 16'($urandom_range(32'(win_hi), 32'(win_lo)));
    end else if (pick < 55) begin
      it.distance_mm = 16'($urandom_range(32'(VALID_LIMIT) - 1, 32'(win_hi)));
    end else if (pick < 70) begin
      case ($urandom_range(7))
        0: it.distance_mm = 16'd0;
        1: it.distance_mm = VALID_LIMIT;
        2: it.distance_mm = NO_ECHO_MM;
        3: it.distance_mm = 16'hFFFF;
        4: it.distance_mm = 16'(win_lo);
        5: it.distance_mm = 16'(win_hi);
        6: it.distance_mm = 16'(win_lo) + 16'd1;
        default: it.distance_mm = 16'(win_hi) - 16'd1;
      endcase
    end else begin
      it.distance_mm = 16'($urandom);
    end
    return it;
  endfunction

  function automatic stim_row_t ev(input logic [2:0] req, input logic [7:0] code,
                                   input logic has_arg, input logic [7:0] arg,
                                   input logic [15:0] mm);
    stim_row_t r;
    r = '0;
    r.kind = ROW_STEP;
    r.item = '{req, code, has_arg, arg, mm};
    return r;
  endfunction

  function automatic stim_row_t typed_ev(input stim_row_t r, input mode_t m,
                                         input logic [2:0] snd, input logic [1:0] msg);
    stim_row_t t;
    t = r;
    t.kind = ROW_CHECKED;
    t.want = '{m, snd, msg, 16'd0, 1'b0, 1'b0};
    return t;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_event(input item_t it, input logic typed, input res_t want);
    res_t forecast;
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({it.distance_mm, it.cmd_arg, it.cmd_has_arg, it.cmd_code});
    s_tuser  <= it.req_type;
    do @(posedge clk); while (!s_tready);
    forecast = advance_unit(it);
    pending_results.push_back(typed ? want : forecast);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ADV_TIMEOUT:   adv_limit = val;
      REG_INACT_TIMEOUT: idle_limit = val;
      REG_WIN_MIN:       win_lo = val[10:0];
      REG_WIN_MAX:       win_hi = val[10:0];
      REG_COOLDOWN:      cool_ms = val[15:0];
      REG_DEBOUNCE:      press_gap = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] adv, input logic [CFG_W-1:0] inact,
                               input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                               input logic [CFG_W-1:0] cool, input logic [CFG_W-1:0] gap);
    drain();
    write_reg(REG_ADV_TIMEOUT, adv);
    write_reg(REG_INACT_TIMEOUT, inact);
    write_reg(REG_WIN_MIN, lo);
    write_reg(REG_WIN_MAX, hi);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_DEBOUNCE, gap);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_event(random_event(), 1'b0, '0);
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] != want.mode)
          report_error($sformatf("result %0d mode: got %0d, want %0d",
                                 results_seen, m_tdata[1:0], want.mode));
        if (m_tdata[4:2] != want.sound)
          report_error($sformatf("result %0d sound: got %0d, want %0d",
                                 results_seen, m_tdata[4:2], want.sound));
        if (m_tdata[6:5] != want.message)
          report_error($sformatf("result %0d message: got %0d, want %0d",
                                 results_seen, m_tdata[6:5], want.message));
        if (m_tdata[22:7] != want.report_distance)
          report_error($sformatf("result %0d report_distance: got %0d, want %0d",
                                 results_seen, m_tdata[22:7], want.report_distance));
        if (m_tdata[23] != want.start_advertising)
          report_error($sformatf("result %0d start_advertising: got %0d, want %0d",
                                 results_seen, m_tdata[23], want.start_advertising));
        if (m_tdata[24] != want.sleep_now)
          report_error($sformatf("result %0d sleep_now: got %0d, want %0d",
                                 results_seen, m_tdata[24], want.sleep_now));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    // power-on registers
    opening_rows.push_back(typed_ev(ev(REQ_TICK, 8'h00, 1'b0, 8'h00, 16'd0),
                                    MODE_ADV, SND_NONE, MSG_NONE));
    opening_rows.push_back(ev(REQ_BUTTON, 8'h00, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(typed_ev(ev(REQ_LINK_DOWN, 8'h00, 1'b0, 8'h00, 16'd0),
                                    MODE_ADV, SND_LINK_DOWN, MSG_NONE));
    opening_rows.push_back(typed_ev(ev(REQ_CMD, CMD_POLL_ON, 1'b1, ARG_CORRECT, 16'd0),
                                    MODE_ADV, SND_NONE, MSG_NONE));
    opening_rows.push_back(typed_ev(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'd500),
                                    MODE_ADV, SND_NONE, MSG_NONE));
    opening_rows.push_back(typed_ev(ev(REQ_UNUSED, 8'hFF, 1'b1, 8'hFF, 16'hFFFF),
                                    MODE_ADV, SND_NONE, MSG_NONE));
    opening_rows.push_back(typed_ev(ev(REQ_LINK_UP, 8'h00, 1'b0, 8'h00, 16'd0),
                                    MODE_CONN, SND_LINK_UP, MSG_NONE));
    opening_rows.push_back(ev(REQ_CMD, CMD_PING, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_CMD, CMD_SND_OK, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_CMD, CMD_SND_BAD, 1'b1, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_CMD, CMD_POLL_OFF, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_CMD, CMD_POLL_ON, 1'b1, ARG_CORRECT, 16'd0));
    opening_rows.push_back(ev(REQ_CMD, CMD_POLL_ON, 1'b1, ARG_CORRECT, 16'd0));
    opening_rows.push_back(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'd500));
    opening_rows.push_back(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'hFFFF));
    opening_rows.push_back(reg_row(REG_COOLDOWN, 26'd0));
    opening_rows.push_back(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'd50));
    opening_rows.push_back(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'd999));
    opening_rows.push_back(ev(REQ_CMD, CMD_POLL_ON, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'd51));
    opening_rows.push_back(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'd1999));
    opening_rows.push_back(ev(REQ_SAMPLE, 8'h00, 1'b0, 8'h00, 16'd51));
    opening_rows.push_back(ev(REQ_LINK_DOWN, 8'h00, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_LINK_UP, 8'h00, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_CMD, CMD_SLEEP, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_TICK, 8'h00, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_BUTTON, 8'h00, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(reg_row(REG_ADV_TIMEOUT, 26'd0));
    opening_rows.push_back(ev(REQ_TICK, 8'h00, 1'b0, 8'h00, 16'd0));
    opening_rows.push_back(ev(REQ_BUTTON, 8'h00, 1'b0, 8'h00, 16'd0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      case (opening_rows[i].kind)
        ROW_REG: begin
          drain();
          write_reg(opening_rows[i].reg_idx, opening_rows[i].reg_val);
        end
        ROW_CHECKED: send_event(opening_rows[i].item, 1'b1, opening_rows[i].want);
        default:     send_event(opening_rows[i].item, 1'b0, '0);
      endcase
    end

    load_settings(26'd40, 26'd120, 26'd50, 26'd1000, 26'd10, 26'd5);
    run_random(300);

    load_settings(26'h3FFFFFF, 26'h3FFFFFF, 26'd0, 26'd2047, 26'd0, 26'd0);
    idle_pct = 0;
    run_random(300);
    idle_pct = IDLE_PCT;

    load_settings(26'd0, 26'd0, 26'd2047, 26'd0, 26'd65535, 26'd65535);
    run_random(100);

    load_settings(26'($urandom_range(100, 10)), 26'($urandom_range(400, 50)),
                  26'($urandom_range(300)), 26'($urandom_range(1500, 400)),
                  26'($urandom_range(50)), 26'($urandom_range(30)));
    run_random(300);

    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
